[sv/fixed_table_huffman_packer_assert.svh]
// Assertion macros for the packer.
`ifndef FIXED_TABLE_HUFFMAN_PACKER_ASSERT_SVH
`define FIXED_TABLE_HUFFMAN_PACKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FHP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FHP_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FHP_ASSERT(label, clk, rst_n, prop, msg)
`define FHP_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[sv/fhp_pkg.sv]
`timescale 1ns / 1ps
package fhp_pkg;
  localparam int unsigned CodeEntries = 257;
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FINISH = 1'b1;
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       last;
    logic [15:0] total_length;
    logic       overflow;
  } result_t;

  // Planned results of one item: up to three, in order.
  typedef struct packed {
    logic [1:0] count;
    result_t [2:0] res;
  } plan_t;

  localparam logic [15:0] CODE_ROM [CodeEntries] = '{
    16'h0002, 16'h01f5, 16'h0226, 16'h0347, 16'h0757, 16'h0286, 16'h03b6, 16'h0327,
    16'h0e08, 16'h0628, 16'h0567, 16'h0798, 16'h19d9, 16'h0978, 16'h02a6, 16'h0577,
    16'h0718, 16'h05b8, 16'h1cc9, 16'h0a78, 16'h0257, 16'h04f7, 16'h0668, 16'h07d8,
    16'h1919, 16'h1ce9, 16'h03f7, 16'h0909, 16'h0598, 16'h07b8, 16'h0918, 16'h0c68,
    16'h02d6, 16'h1869, 16'h06f8, 16'h0939, 16'h1cca, 16'h05a8, 16'h1aea, 16'h1c0a,
    16'h1489, 16'h14a9, 16'h0829, 16'h19fa, 16'h1719, 16'h1209, 16'h0e79, 16'h1f3a,
    16'h14b9, 16'h1009, 16'h1909, 16'h0136, 16'h1619, 16'h1259, 16'h1339, 16'h1959,
    16'h1739, 16'h1ca9, 16'h0869, 16'h1e99, 16'h0db9, 16'h1ec9, 16'h08b9, 16'h0859,
    16'h00a5, 16'h0968, 16'h09c8, 16'h1c39, 16'h19c9, 16'h08f9, 16'h18f9, 16'h0919,
    16'h0879, 16'h0c69, 16'h1779, 16'h0899, 16'h0d69, 16'h08c9, 16'h1ee9, 16'h1eb9,
    16'h0849, 16'h1649, 16'h1759, 16'h1cd9, 16'h05e8, 16'h0889, 16'h12b9, 16'h1729,
    16'h10a9, 16'h08d9, 16'h13a9, 16'h11c9, 16'h1e1a, 16'h1e0a, 16'h1879, 16'h1dca,
    16'h1dfa, 16'h0747, 16'h19f9, 16'h08d8, 16'h0e48, 16'h0797, 16'h0ea9, 16'h0e19,
    16'h0408, 16'h0417, 16'h10b9, 16'h0b09, 16'h06a8, 16'h0c18, 16'h0717, 16'h0787,
    16'h0b18, 16'h14c9, 16'h0437, 16'h0768, 16'h0667, 16'h04d7, 16'h08a9, 16'h02f6,
    16'h0c98, 16'h0ce9, 16'h1499, 16'h1609, 16'h1baa, 16'h19ea, 16'h39fa, 16'h0e59,
    16'h1949, 16'h1849, 16'h1269, 16'h0307, 16'h06c8, 16'h1219, 16'h1e89, 16'h1c1a,
    16'h11da, 16'h163a, 16'h385a, 16'h3dba, 16'h17da, 16'h106a, 16'h397a, 16'h24ea,
    16'h02e7, 16'h0988, 16'h33ca, 16'h32ea, 16'h1e9a, 16'h0bf9, 16'h3dfa, 16'h1dda,
    16'h32da, 16'h2eda, 16'h30ba, 16'h107a, 16'h2e8a, 16'h3dea, 16'h125a, 16'h1e8a,
    16'h0e99, 16'h1cda, 16'h1b5a, 16'h1659, 16'h232a, 16'h2e1a, 16'h3aeb, 16'h3c6b,
    16'h3e2b, 16'h205a, 16'h29aa, 16'h248a, 16'h2cda, 16'h23ba, 16'h3c5b, 16'h251a,
    16'h2e9a, 16'h252a, 16'h1ea9, 16'h3a0b, 16'h391b, 16'h23ca, 16'h392b, 16'h3d5b,
    16'h233a, 16'h2cca, 16'h390b, 16'h1bba, 16'h3a1b, 16'h3c4b, 16'h211a, 16'h203a,
    16'h12a9, 16'h231a, 16'h3e0b, 16'h29ba, 16'h3d7b, 16'h202a, 16'h3adb, 16'h213a,
    16'h253a, 16'h32ca, 16'h23da, 16'h23fa, 16'h32fa, 16'h11ca, 16'h384a, 16'h31ca,
    16'h17ca, 16'h30aa, 16'h2e0a, 16'h276a, 16'h250a, 16'h3e3b, 16'h396a, 16'h18fa,
    16'h204a, 16'h206a, 16'h230a, 16'h265a, 16'h212a, 16'h23ea, 16'h3acb, 16'h393b,
    16'h3e1b, 16'h1dea, 16'h3d6b, 16'h31da, 16'h3e5b, 16'h3e4b, 16'h207a, 16'h3c7b,
    16'h277a, 16'h3d4b, 16'h0c08, 16'h162a, 16'h3daa, 16'h124a, 16'h1b4a, 16'h264a,
    16'h33da, 16'h1d1a, 16'h1afa, 16'h39ea, 16'h24fa, 16'h373b, 16'h249a, 16'h372b,
    16'h1679, 16'h210a, 16'h23aa, 16'h1b8a, 16'h3afb, 16'h18ea, 16'h2eca, 16'h0627,
    16'h00d4
  };
endpackage

[sv/fhp_if.sv]
`timescale 1ns / 1ps
interface fhp_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] symbol;
  modport source (output valid, opcode, symbol, input ready);
  modport sink (input valid, opcode, symbol, output ready);
endinterface

interface fhp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic        last;
  logic [15:0] total_length;
  logic        overflow;
  modport source (output valid, kind, data_byte, last, total_length, overflow,
                  input ready);
  modport sink (input valid, kind, data_byte, last, total_length, overflow,
                output ready);
endinterface

[sv/fhp_encoder.sv]
`timescale 1ns / 1ps
// Computes the results and the next message state for one item.
module fhp_encoder import fhp_pkg::*; (
  input  logic        opcode,
  input  logic [7:0]  symbol,
  input  logic [15:0] limit,
  input  logic [7:0]  pend_bits,
  input  logic [2:0]  pend_cnt,
  input  logic [16:0] emitted,
  input  logic        ovf,
  output plan_t       plan,
  output logic [7:0]  pend_bits_nxt,
  output logic [2:0]  pend_cnt_nxt,
  output logic [16:0] emitted_nxt,
  output logic        ovf_nxt
);
  logic [15:0] word;
  logic [11:0] code;
  logic [3:0]  len;
  logic [4:0]  avail;
  logic [4:0]  take;
  logic [22:0] acc;
  logic [4:0]  total;
  logic [1:0]  nbytes;
  logic        blocked;
  logic [2:0]  rem;
  logic [7:0]  remv;
  logic [16:0] em2;
  logic [16:0] lim17;
  logic [16:0] gap;
  logic        pad_ok;
  result_t     r;

  always_comb begin
    word = (opcode == OP_FINISH) ? CODE_ROM[CodeEntries-1] : CODE_ROM[symbol];
    code = word[15:4];
    len = word[3:0];
    lim17 = {1'b0, limit};
    // Bytes left before the count reaches the limit, and the bits that this item may add.
    gap = (emitted >= lim17) ? 17'd0 : (lim17 - emitted);
    if (gap == 17'd0) avail = 5'd0;
    else if (gap == 17'd1) avail = 5'd8 - {2'b0, pend_cnt};
    else if (gap == 17'd2) avail = 5'd16 - {2'b0, pend_cnt};
    else avail = 5'd24 - {2'b0, pend_cnt};
    take = {1'b0, len};
    blocked = 1'b0;
    pad_ok = 1'b0;
    if (ovf) begin
      take = 5'd0;
    end else if ({1'b0, len} > avail) begin
      take = avail;
      blocked = 1'b1;
    end
    acc = ({15'd0, pend_bits} << take) |
          ({11'd0, code} >> (5'(len) - take));
    total = {2'b0, pend_cnt} + take;
    nbytes = 2'(total >> 3);
    rem = total[2:0];
    remv = 8'(acc & ((23'd1 << rem) - 23'd1));
    em2 = emitted + {15'd0, nbytes};
    ovf_nxt = ovf | blocked;
    plan = '0;
    r = '0;
    for (int i = 0; i < 2; i++) begin
      if (2'(i) < nbytes) begin
        r = '0;
        r.kind = KIND_DATA;
        r.data_byte = 8'(acc >> ({3'd0, rem} + 5'((nbytes - 2'(i) - 2'd1) * 4'd8)));
        plan.res[i] = r;
      end
    end
    plan.count = nbytes;
    pend_bits_nxt = remv;
    pend_cnt_nxt = rem;
    emitted_nxt = em2;
    if (opcode == OP_FINISH) begin
      if (!ovf_nxt && rem != 3'd0) begin
        if (em2 >= lim17) ovf_nxt = 1'b1;
        else pad_ok = 1'b1;
      end
      if (pad_ok) begin
        r = '0;
        r.kind = KIND_DATA;
        r.data_byte = 8'(remv << (4'd8 - {1'b0, rem}));
        plan.res[plan.count] = r;
        em2 = em2 + 17'd1;
      end
      r = '0;
      r.kind = KIND_STATUS;
      r.overflow = ovf_nxt;
      r.total_length = ovf_nxt ? 16'd0 : em2[15:0];
      plan.res[plan.count + 2'(pad_ok)] = r;
      plan.count = plan.count + 2'(pad_ok) + 2'd1;
      pend_bits_nxt = '0;
      pend_cnt_nxt = '0;
      emitted_nxt = '0;
      ovf_nxt = 1'b0;
    end
    if (plan.count != 2'd0) plan.res[plan.count - 2'd1].last = 1'b1;
  end
endmodule

[sv/fixed_table_huffman_packer.sv]
`timescale 1ns / 1ps
// The first result of an item is registered and shown in the cycle after its transfer.
// Results drain one at a time from the item's registered result queue as out_ch accepts them;
// a new item is taken only when the queue is empty or in the cycle that its last result is popped.
// Reset (rst_n low, synchronous) clears the message state, the result queue
// and sets the byte limit (limit_r) to 65535.
`include "fixed_table_huffman_packer_assert.svh"
module fixed_table_huffman_packer import fhp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  fhp_in_if.sink      in_ch,
  fhp_out_if.source   out_ch
);
  logic [15:0] limit_r;
  logic [7:0]  pend_bits_r;
  logic [2:0]  pend_cnt_r;
  logic [16:0] emitted_r;
  logic        ovf_r;
  result_t [2:0] q_r;
  logic [1:0]  cnt_r;
  logic [1:0]  idx_r;
  plan_t       plan;
  logic [7:0]  pb_nxt;
  logic [2:0]  pc_nxt;
  logic [16:0] em_nxt;
  logic        ov_nxt;
  logic        pop;
  logic        drain;
  logic        take;

  fhp_encoder u_enc (
    .opcode(in_ch.opcode), .symbol(in_ch.symbol), .limit(limit_r),
    .pend_bits(pend_bits_r), .pend_cnt(pend_cnt_r), .emitted(emitted_r),
    .ovf(ovf_r), .plan(plan), .pend_bits_nxt(pb_nxt), .pend_cnt_nxt(pc_nxt),
    .emitted_nxt(em_nxt), .ovf_nxt(ov_nxt)
  );

  assign pop = out_ch.valid && out_ch.ready;
  assign drain = (cnt_r == 2'd0) || (pop && idx_r + 2'd1 == cnt_r);
  assign in_ch.ready = drain;
  assign take = in_ch.valid && in_ch.ready;
  assign out_ch.valid = cnt_r != 2'd0;
  assign out_ch.kind = q_r[idx_r].kind;
  assign out_ch.data_byte = q_r[idx_r].data_byte;
  assign out_ch.last = q_r[idx_r].last;
  assign out_ch.total_length = q_r[idx_r].total_length;
  assign out_ch.overflow = q_r[idx_r].overflow;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 16'hFFFF;
      pend_bits_r <= '0;
      pend_cnt_r <= '0;
      emitted_r <= '0;
      ovf_r <= 1'b0;
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      if (take) begin
        pend_bits_r <= pb_nxt;
        pend_cnt_r <= pc_nxt;
        emitted_r <= em_nxt;
        ovf_r <= ov_nxt;
        q_r <= plan.res;
        cnt_r <= plan.count;
        idx_r <= '0;
      end else if (drain) begin
        cnt_r <= '0;
        idx_r <= '0;
      end else if (pop) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  `FHP_ASSERT(a_idx_in_range, clk, rst_n, out_ch.valid |-> idx_r < cnt_r, "index past queue")
  `FHP_ASSERT(a_ready_last, clk, rst_n, (out_ch.valid && in_ch.ready) |-> out_ch.last, "ready before last result")
  `FHP_ASSERT(a_pend_cnt_zero_finish, clk, rst_n, (take && in_ch.opcode == OP_FINISH) |=> (pend_cnt_r == 3'd0 && emitted_r == 17'd0), "state not cleared")
endmodule

[tb/fixed_table_huffman_packer_test.sv]
`timescale 1ns / 1ps
module fixed_table_huffman_packer_test;
  import fhp_pkg::*;

  class packer_scoreboard;
    logic [15:0] byte_limit;
    logic [7:0] partial_bits;
    int unsigned partial_count;
    int unsigned byte_count;
    bit limit_hit;
    result_t pending_results[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      byte_limit = 16'hFFFF;
      partial_bits = 0;
      partial_count = 0;
      byte_count = 0;
      limit_hit = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void add_result(logic kind, logic [7:0] data, logic [15:0] total, logic ovf);
      result_t r;
      r.kind = kind;
      r.data_byte = data;
      r.last = 1'b0;
      r.total_length = total;
      r.overflow = ovf;
      pending_results.push_back(r);
    endfunction

    function void append_code(logic [15:0] word);
      int len;
      logic [11:0] code;
      len = word[3:0];
      code = word[15:4];
      while (len > 0 && !limit_hit) begin
        len--;
        if (byte_count >= byte_limit) begin
          limit_hit = 1;
          break;
        end
        partial_bits = {partial_bits[6:0], code[len]};
        partial_count++;
        if (partial_count == 8) begin
          add_result(KIND_DATA, partial_bits, 16'd0, 1'b0);
          partial_count = 0;
          partial_bits = 0;
          byte_count++;
        end
      end
    endfunction

    function void note_input(logic opcode, logic [7:0] symbol);
      int unsigned before_count;
      logic [7:0] pad;
      result_t r;
      before_count = pending_results.size();
      if (opcode == OP_ENCODE) begin
        append_code(CODE_ROM[symbol]);
      end else begin
        append_code(CODE_ROM[CodeEntries - 1]);
        if (!limit_hit && partial_count != 0) begin
          if (byte_count >= byte_limit) begin
            limit_hit = 1;
          end else begin
            pad = partial_bits << (8 - partial_count);
            add_result(KIND_DATA, pad, 16'd0, 1'b0);
            byte_count++;
          end
        end
        if (limit_hit) add_result(KIND_STATUS, 8'd0, 16'd0, 1'b1);
        else add_result(KIND_STATUS, 8'd0, byte_count[15:0], 1'b0);
        partial_bits = 0;
        partial_count = 0;
        byte_count = 0;
        limit_hit = 0;
      end
      if (pending_results.size() > before_count) begin
        r = pending_results.pop_back();
        r.last = 1'b1;
        pending_results.push_back(r);
      end
    endfunction

    task check_result(result_t got);
      result_t want;
      checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
      if (got.data_byte !== want.data_byte)
        report_mismatch($sformatf("data_byte %h, wanted %h", got.data_byte, want.data_byte));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0d, wanted %0d", got.last, want.last));
      if (got.total_length !== want.total_length)
        report_mismatch($sformatf("total_length %0d, wanted %0d",
                                  got.total_length, want.total_length));
      if (got.overflow !== want.overflow)
        report_mismatch($sformatf("overflow %0d, wanted %0d", got.overflow, want.overflow));
    endtask
  endclass

  localparam int StallLimit = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  bit calm_phase = 0;
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;

  fhp_in_if in_ch();
  fhp_out_if out_ch();
  packer_scoreboard board;

  fixed_table_huffman_packer dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_ENCODE;
    in_ch.symbol = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) board.note_input(in_ch.opcode, in_ch.symbol);
      if (out_ch.valid && out_ch.ready) begin
        board.check_result({out_ch.kind, out_ch.data_byte, out_ch.last,
                            out_ch.total_length, out_ch.overflow});
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("Watchdog: no transfer for %0d cycles", StallLimit);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm_phase || ($urandom_range(99) >= 20);
  end

  task automatic send_item(logic opcode, logic [7:0] symbol);
    while (!calm_phase && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= opcode;
    in_ch.symbol <= symbol;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (board.pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_limit(logic [15:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.byte_limit = value;
  endtask

  task automatic send_message(int unsigned symbols);
    for (int unsigned i = 0; i < symbols; i++) begin
      send_item(OP_ENCODE, 8'($urandom_range(255)));
    end
    send_item(OP_FINISH, 8'($urandom_range(255)));
  endtask

  initial begin
    logic [15:0] limits[6];
    board = new();
    limits = '{16'd0, 16'd1, 16'd3, 16'd9, 16'd40, 16'hFFFF};
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(OP_FINISH, 8'h00);
    send_item(OP_ENCODE, 8'h00);
    send_item(OP_ENCODE, 8'hFF);
    send_item(OP_ENCODE, 8'h80);
    send_item(OP_ENCODE, 8'h7F);
    send_item(OP_ENCODE, 8'hAA);
    send_item(OP_ENCODE, 8'h55);
    send_item(OP_FINISH, 8'hFF);
    set_limit(16'd0);
    send_item(OP_ENCODE, 8'h41);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_FINISH, 8'h00);
    set_limit(16'd2);
    for (int i = 0; i < 6; i++) send_item(OP_ENCODE, 8'hC0 + 8'(i));
    send_item(OP_FINISH, 8'h00);
    set_limit(16'd1);
    send_item(OP_ENCODE, 8'h01);
    send_item(OP_FINISH, 8'h00);
    set_limit(16'hFFFF);

    while (items_sent < 460) begin
      if ($urandom_range(9) == 0) set_limit(limits[$urandom_range(5)]);
      calm_phase = (items_sent >= 250 && items_sent < 320);
      if ($urandom_range(9) == 0) send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
      else send_message($urandom_range(12));
    end
    calm_phase = 0;
    send_item(OP_FINISH, 8'h00);

    drain_results();
    $display("Sent %0d items and checked %0d results over limits from 0 to 65535.",
             items_sent, board.checked);
    $display("Messages covered overflow, zero limit and mid-stream limit changes.");
    if (error_count == 0 && board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

[tb/unused_placeholder_removed.sv]
`timescale 1ns / 1ps
